// ===== rtl/core/sws_pkg.sv =====
// Shared types, register map and constants for the stopwatch with split.
`default_nettype none
package sws_pkg;

	localparam int LIMIT_W  = 14;
	localparam int SAMPLE_W = 8;
	localparam int COUNT_W  = 8;
	localparam int BLINK_W  = 10;
	localparam int CFG_W    = 14;
	localparam int IDX_W    = 2;
	localparam int DIGITS_W = 16;

	localparam logic [IDX_W-1:0] REG_COUNT_LIMIT   = 2'd0;
	localparam logic [IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd1;
	localparam logic [IDX_W-1:0] REG_COUNT_PERIOD  = 2'd2;
	localparam logic [IDX_W-1:0] REG_BLINK_PERIOD  = 2'd3;

	localparam logic [LIMIT_W-1:0]  RST_COUNT_LIMIT   = 14'd6000;
	localparam logic [SAMPLE_W-1:0] RST_SAMPLE_PERIOD = 8'd25;
	localparam logic [COUNT_W-1:0]  RST_COUNT_PERIOD  = 8'd10;
	localparam logic [BLINK_W-1:0]  RST_BLINK_PERIOD  = 10'd250;

	localparam logic [1:0] MODE_RESET = 2'd0;
	localparam logic [1:0] MODE_RUN   = 2'd1;
	localparam logic [1:0] MODE_STOP  = 2'd2;
	localparam logic [1:0] MODE_SPLIT = 2'd3;

	typedef struct packed {
		logic [LIMIT_W-1:0]  count_limit;
		logic [SAMPLE_W-1:0] sample_period;
		logic [COUNT_W-1:0]  count_period;
		logic [BLINK_W-1:0]  blink_period;
	} cfg_t;

	typedef struct packed {
		logic [DIGITS_W-1:0] digits;
		logic                point;
		logic [1:0]          mode;
	} result_t;

	// four-digit BCD increment, 9999 rolls over to 0000
	function automatic logic [DIGITS_W-1:0] bcd_inc(input logic [DIGITS_W-1:0] v);
		logic [DIGITS_W-1:0] r;
		logic                carry;
		r     = v;
		carry = 1'b1;
		for (int d = 0; d < 4; d++) begin
			if (carry) begin
				if (v[d*4 +: 4] == 4'd9) begin
					r[d*4 +: 4] = 4'd0;
				end else begin
					r[d*4 +: 4] = v[d*4 +: 4] + 4'd1;
					carry       = 1'b0;
				end
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sws_prescale.sv =====
// Tick prescaler: counts beats and fires when the count reaches its period.
`default_nettype none
module sws_prescale #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [WIDTH-1:0] period,
	output logic                  fire
);

	logic [WIDTH-1:0] pre_q;
	logic [WIDTH:0]   next_val;

	assign next_val = {1'b0, pre_q} + {{WIDTH{1'b0}}, 1'b1};
	assign fire     = next_val >= {1'b0, period};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q <= '0;
		end else if (step) begin
			pre_q <= fire ? '0 : next_val[WIDTH-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sws_ctrl.sv =====
// Stopwatch state: button sampling, edge detect, mode, counters and blink.
`default_nettype none
module sws_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire logic           start_level,
	input  wire logic           split_level,
	input  wire sws_pkg::cfg_t  cfg,
	output sws_pkg::result_t    result
);

	logic samp_fire, count_fire, blink_fire;

	logic [1:0]                     latched_q, prev_q, mode_q;
	logic [sws_pkg::LIMIT_W-1:0]    elapsed_q;
	logic [sws_pkg::DIGITS_W-1:0]   bcd_q, held_q;
	logic                           blink_q;

	logic [1:0]                     latched_d, edges, mode_d;
	logic [sws_pkg::LIMIT_W-1:0]    elapsed_d;
	logic [sws_pkg::DIGITS_W-1:0]   bcd_d, held_d;
	logic                           blink_d, moving;

	sws_prescale #(.WIDTH(sws_pkg::SAMPLE_W)) u_samp (
		.clk(clk), .arst_n(arst_n), .step(step),
		.period(cfg.sample_period), .fire(samp_fire)
	);

	sws_prescale #(.WIDTH(sws_pkg::COUNT_W)) u_count (
		.clk(clk), .arst_n(arst_n), .step(step),
		.period(cfg.count_period), .fire(count_fire)
	);

	sws_prescale #(.WIDTH(sws_pkg::BLINK_W)) u_blink (
		.clk(clk), .arst_n(arst_n), .step(step),
		.period(cfg.blink_period), .fire(blink_fire)
	);

	assign latched_d = samp_fire ? {split_level, start_level} : latched_q;
	assign edges     = latched_d & ~prev_q;
	assign blink_d   = blink_q ^ blink_fire;

	always_comb begin
		elapsed_d = elapsed_q;
		bcd_d     = bcd_q;
		held_d    = held_q;
		mode_d    = mode_q;

		// bcd_q shadows elapsed_q modulo 10000
		if (count_fire && (mode_q == sws_pkg::MODE_RUN || mode_q == sws_pkg::MODE_SPLIT)) begin
			if (elapsed_q >= cfg.count_limit) begin
				elapsed_d = '0;
				bcd_d     = '0;
			end else begin
				elapsed_d = elapsed_q + 14'd1;
				bcd_d     = sws_pkg::bcd_inc(bcd_q);
			end
		end

		if (edges[0]) begin
			case (mode_q)
				sws_pkg::MODE_RESET: mode_d = sws_pkg::MODE_RUN;
				sws_pkg::MODE_RUN:   mode_d = sws_pkg::MODE_STOP;
				sws_pkg::MODE_STOP:  mode_d = sws_pkg::MODE_RUN;
				default:             mode_d = sws_pkg::MODE_STOP;
			endcase
		end

		// split acts on the mode left by the start edge
		if (edges[1]) begin
			case (mode_d)
				sws_pkg::MODE_RESET: mode_d = sws_pkg::MODE_RESET;
				sws_pkg::MODE_RUN: begin
					mode_d = sws_pkg::MODE_SPLIT;
					held_d = bcd_d;
				end
				sws_pkg::MODE_STOP: begin
					mode_d    = sws_pkg::MODE_RESET;
					elapsed_d = '0;
					bcd_d     = '0;
				end
				default: mode_d = sws_pkg::MODE_RUN;
			endcase
		end
	end

	assign moving        = (mode_d == sws_pkg::MODE_RUN) || (mode_d == sws_pkg::MODE_SPLIT);
	assign result.digits = (mode_d == sws_pkg::MODE_SPLIT) ? held_d : bcd_d;
	assign result.point  = moving ? blink_d : 1'b1;
	assign result.mode   = mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q <= '0;
			prev_q    <= '0;
			mode_q    <= sws_pkg::MODE_RESET;
			elapsed_q <= '0;
			bcd_q     <= '0;
			held_q    <= '0;
			blink_q   <= 1'b0;
		end else if (step) begin
			latched_q <= latched_d;
			prev_q    <= latched_d;
			mode_q    <= mode_d;
			elapsed_q <= elapsed_d;
			bcd_q     <= bcd_d;
			held_q    <= held_d;
			blink_q   <= blink_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/stopwatch_with_split.sv =====
// Top level of the stopwatch with split: config registers and result register.
//
// One input beat is one 1 ms tick carrying the raw start/stop and
// split/reset button levels (item_valid/item_ready). Each accepted beat
// produces exactly one result beat (result_valid/result_ready) holding four
// BCD digits of the shown time, the decimal point and the mode after the tick.
// The tick updates the state and the result register at the same edge, and
// result_valid rises on the next cycle. Throughput is one beat per cycle
// while result_ready stays high. item_ready is high whenever the result
// register is empty or being taken this cycle, so a stalled receiver holds
// the pending result and back-pressures the input by a single beat.
// The config port (cfg_we, cfg_index, cfg_data) writes one of count_limit,
// sample_period, count_period and blink_period, as cfg_index selects; write
// it only while no beat is in flight.
// Reset clears all prescalers, the mode (reset), counts and blink bit, sets
// the config registers to their defaults and empties the result register.
`default_nettype none
module stopwatch_with_split (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic                          start_level,
	input  wire logic                          split_level,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic [sws_pkg::DIGITS_W-1:0]       display_digits,
	output logic                               point_on,
	output logic [1:0]                         mode_now,
	input  wire logic                          cfg_we,
	input  wire logic [sws_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [sws_pkg::CFG_W-1:0]     cfg_data
);

	sws_pkg::cfg_t    cfg_q;
	sws_pkg::result_t res;
	logic             step;
	logic             valid_q;
	logic [sws_pkg::DIGITS_W-1:0] digits_q;
	logic             point_q;
	logic [1:0]       mode_q;

	assign item_ready = !valid_q || result_ready;
	assign step       = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_limit   <= sws_pkg::RST_COUNT_LIMIT;
			cfg_q.sample_period <= sws_pkg::RST_SAMPLE_PERIOD;
			cfg_q.count_period  <= sws_pkg::RST_COUNT_PERIOD;
			cfg_q.blink_period  <= sws_pkg::RST_BLINK_PERIOD;
		end else if (cfg_we) begin
			case (cfg_index)
				sws_pkg::REG_COUNT_LIMIT:   cfg_q.count_limit   <= cfg_data;
				sws_pkg::REG_SAMPLE_PERIOD: cfg_q.sample_period <= cfg_data[sws_pkg::SAMPLE_W-1:0];
				sws_pkg::REG_COUNT_PERIOD:  cfg_q.count_period  <= cfg_data[sws_pkg::COUNT_W-1:0];
				sws_pkg::REG_BLINK_PERIOD:  cfg_q.blink_period  <= cfg_data[sws_pkg::BLINK_W-1:0];
				default: ;
			endcase
		end
	end

	sws_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.start_level (start_level),
		.split_level (split_level),
		.cfg         (cfg_q),
		.result      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			digits_q <= res.digits;
			point_q  <= res.point;
			mode_q   <= res.mode;
		end
	end

	assign result_valid   = valid_q;
	assign display_digits = digits_q;
	assign point_on       = point_q;
	assign mode_now       = mode_q;

endmodule
`default_nettype wire

// ===== rtl/core/sws_checker.sv =====
// Port-level checks for the stopwatch with split, bound to the top level.
`default_nettype none
module sws_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_ready,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic [15:0] display_digits,
	input wire logic        point_on,
	input wire logic [1:0]  mode_now
);

	// input only stalls while a result beat is held back
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (result_valid && !result_ready))
		else $error("item_ready low without a stalled result");

	// every accepted tick shows up as a result on the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> result_valid)
		else $error("accepted tick produced no result");

	// point is forced on unless the watch is moving
	a_point: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (mode_now == sws_pkg::MODE_RESET ||
			mode_now == sws_pkg::MODE_STOP)) |-> point_on)
		else $error("point off while reset or stopped");

	// every nibble is a decimal digit
	a_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (display_digits[3:0] <= 4'd9 && display_digits[7:4] <= 4'd9 &&
			display_digits[11:8] <= 4'd9 && display_digits[15:12] <= 4'd9))
		else $error("display nibble out of BCD range");

	// a result leaves only when it is taken: after a stall it must still be there
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> result_valid)
		else $error("stalled result dropped");

endmodule

bind stopwatch_with_split sws_checker u_sws_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item_valid),
	.item_ready     (item_ready),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.display_digits (display_digits),
	.point_on       (point_on),
	.mode_now       (mode_now)
);
`default_nettype wire
